@@ hdl/lrsf_pkg.sv @@
// Shared constants, register codes and types for the lidar range slew filter.
// No dependencies; compile first.
package lrsf_pkg;

  localparam int unsigned RANGE_W   = 16;
  localparam int unsigned TIME_W    = 18;
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned DIGIT_W   = 4;

  localparam int unsigned COEF_FRAC_BITS_DEF  = 14;
  localparam int unsigned STATE_FRAC_BITS_DEF = 16;

  localparam logic [RANGE_W-1:0] SAMPLE_PERIOD_RST   = 16'd1311;
  localparam logic [RANGE_W-1:0] SLEW_LIMIT_RST      = 16'd2176;
  localparam logic [RANGE_W-1:0] JUMP_LIMIT_RST      = 16'd20480;
  localparam logic [TIME_W-1:0]  PREFILL_TIME_RST    = 18'd65536;
  localparam logic [TIME_W-1:0]  BYPASS_TIME_RST     = 18'd196608;
  localparam logic [RANGE_W-1:0] MAX_VALID_RANGE_RST = 16'd25600;
  localparam logic [RANGE_W-1:0] DROPOUT_FLOOR_RST   = 16'd26;
  localparam logic [RANGE_W-1:0] REACQUIRE_FLOOR_RST = 16'd640;

  // filter coefficients in units of 1e-4
  localparam int unsigned K_AA = 4320;
  localparam int unsigned K_AB = 3474;
  localparam int unsigned K_AR = 1210;
  localparam int unsigned K_BA = 3474;
  localparam int unsigned K_BB = 9157;
  localparam int unsigned K_BR = 294;
  localparam int unsigned K_YA = 4984;
  localparam int unsigned K_YB = 27482;
  localparam int unsigned K_YR = 421;

  typedef enum logic [2:0] {
    REG_SAMPLE_PERIOD,
    REG_SLEW_LIMIT,
    REG_JUMP_LIMIT,
    REG_PREFILL_TIME,
    REG_BYPASS_TIME,
    REG_MAX_VALID_RANGE,
    REG_DROPOUT_FLOOR,
    REG_REACQUIRE_FLOOR
  } lrsf_reg_e;

  typedef struct packed {
    logic start;
    logic accum;
  } lrsf_mul_cmd_t;

  // round-to-nearest fixed-point coefficient
  function automatic longint unsigned lrsf_coef(input int unsigned k,
                                                input int unsigned frac);
    return ((longint'(k) << frac) + 64'd5000) / 64'd10000;
  endfunction

endpackage

@@ hdl/lrsf_in_if.sv @@
// Input channel of the lidar range slew filter: one raw range per beat.
// Depends on lrsf_pkg.
interface lrsf_in_if import lrsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] raw_range;

  modport source (output valid, output raw_range, input ready);
  modport sink   (input valid, input raw_range, output ready);
endinterface

@@ hdl/lrsf_out_if.sv @@
// Result channel of the lidar range slew filter: conditioned range per beat.
// Depends on lrsf_pkg.
interface lrsf_out_if import lrsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] out_range;
  logic               filter_active;

  modport source (output valid, output out_range, output filter_active, input ready);
  modport sink   (input valid, input out_range, input filter_active, output ready);
endinterface

@@ hdl/lidar_range_slew_filter.sv @@
// Lidar range slew filter top level: APB register file, sample sequencer, IIR filter.
// Depends on lrsf_pkg, lrsf_in_if, lrsf_out_if and lrsf_sermul.
//
// One raw range sample is taken per beat and one conditioned range is returned for it.
// Each sample runs eleven products (two for the rate limits, nine for the IIR filter)
// through one shared multiplier that consumes four multiplier bits per cycle. The next
// sample is accepted while the previous result still waits in the output register.
// Registers are to be written over APB only while the block is idle; the block itself
// does not enforce this. Reads return the current register values.
module lidar_range_slew_filter import lrsf_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
  parameter int unsigned STATE_FRAC_BITS = STATE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrsf_in_if.sink            sample_i,
  lrsf_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned CW    = COEF_FRAC_BITS + 2;
  localparam int unsigned SER_W = (CW > RANGE_W) ? CW : RANGE_W;
  localparam int unsigned ACC_W = COEF_FRAC_BITS + STATE_FRAC_BITS + 36;
  localparam int unsigned Y_SH  = COEF_FRAC_BITS + STATE_FRAC_BITS;

  localparam logic [SER_W-1:0] C_AA = SER_W'(lrsf_coef(K_AA, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_AB = SER_W'(lrsf_coef(K_AB, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_AR = SER_W'(lrsf_coef(K_AR, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_BA = SER_W'(lrsf_coef(K_BA, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_BB = SER_W'(lrsf_coef(K_BB, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_BR = SER_W'(lrsf_coef(K_BR, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_YA = SER_W'(lrsf_coef(K_YA, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_YB = SER_W'(lrsf_coef(K_YB, COEF_FRAC_BITS));
  localparam logic [SER_W-1:0] C_YR = SER_W'(lrsf_coef(K_YR, COEF_FRAC_BITS));

  localparam logic signed [ACC_W-1:0] HALF_C =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF_Y =
    {{(ACC_W-Y_SH){1'b0}}, 1'b1, {(Y_SH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] S32_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] S32_MIN = ~S32_MAX;
  localparam logic signed [ACC_W-1:0] Y_MAX   =
    {{(ACC_W-RANGE_W){1'b0}}, {RANGE_W{1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN = ~ST_MAX;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_JUMP, S_STEP, S_LIMIT, S_FILT, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    T_AA, T_AB, T_AR, T_BA, T_BB, T_BR, T_YA, T_YB, T_YR
  } term_e;

  // configuration registers
  logic [RANGE_W-1:0] sample_period_q, slew_limit_q, jump_limit_q;
  logic [TIME_W-1:0]  prefill_time_q, bypass_time_q;
  logic [RANGE_W-1:0] max_valid_q, dropout_q, reacquire_q;
  logic               cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= SAMPLE_PERIOD_RST;
      slew_limit_q    <= SLEW_LIMIT_RST;
      jump_limit_q    <= JUMP_LIMIT_RST;
      prefill_time_q  <= PREFILL_TIME_RST;
      bypass_time_q   <= BYPASS_TIME_RST;
      max_valid_q     <= MAX_VALID_RANGE_RST;
      dropout_q       <= DROPOUT_FLOOR_RST;
      reacquire_q     <= REACQUIRE_FLOOR_RST;
    end else if (cfg_wr) begin
      unique case (lrsf_reg_e'(paddr[PADDR_W-1:2]))
        REG_SAMPLE_PERIOD:   sample_period_q <= pwdata[RANGE_W-1:0];
        REG_SLEW_LIMIT:      slew_limit_q    <= pwdata[RANGE_W-1:0];
        REG_JUMP_LIMIT:      jump_limit_q    <= pwdata[RANGE_W-1:0];
        REG_PREFILL_TIME:    prefill_time_q  <= pwdata[TIME_W-1:0];
        REG_BYPASS_TIME:     bypass_time_q   <= pwdata[TIME_W-1:0];
        REG_MAX_VALID_RANGE: max_valid_q     <= pwdata[RANGE_W-1:0];
        REG_DROPOUT_FLOOR:   dropout_q       <= pwdata[RANGE_W-1:0];
        REG_REACQUIRE_FLOOR: reacquire_q     <= pwdata[RANGE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (lrsf_reg_e'(paddr[PADDR_W-1:2]))
      REG_SAMPLE_PERIOD:   prdata = DATA_W'(sample_period_q);
      REG_SLEW_LIMIT:      prdata = DATA_W'(slew_limit_q);
      REG_JUMP_LIMIT:      prdata = DATA_W'(jump_limit_q);
      REG_PREFILL_TIME:    prdata = DATA_W'(prefill_time_q);
      REG_BYPASS_TIME:     prdata = DATA_W'(bypass_time_q);
      REG_MAX_VALID_RANGE: prdata = DATA_W'(max_valid_q);
      REG_DROPOUT_FLOOR:   prdata = DATA_W'(dropout_q);
      REG_REACQUIRE_FLOOR: prdata = DATA_W'(reacquire_q);
    endcase
  end

  // sequencer state and item state
  state_e                    state_q;
  term_e                     term_q;
  logic                      pend_q;
  logic [RANGE_W-1:0]        raw_q, diff_q, step_q, y_q;
  logic                      jump_q;
  logic [TIME_W-1:0]         elapsed_q;
  logic [RANGE_W-1:0]        prev_raw_q, prev_limited_q;
  logic signed [STATE_W-1:0] state_a_q, state_b_q, na_q;
  logic                      out_valid_q, out_active_q;
  logic [RANGE_W-1:0]        out_range_q;

  // multiplier
  lrsf_mul_cmd_t           mul_cmd;
  logic signed [ACC_W-1:0] mcand, acc;
  logic [SER_W-1:0]        mplier;
  logic                    mul_done;

  lrsf_sermul #(
    .ACC_W (ACC_W),
    .SER_W (SER_W)
  ) u_sermul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mul_cmd),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .done_o   (mul_done),
    .acc_o    (acc)
  );

  // front end
  logic [TIME_W:0]    elapsed_sum;
  logic [TIME_W-1:0]  elapsed_nx;
  logic               seed;
  logic [RANGE_W-1:0] pr, pl, r1, r2, diff;

  always_comb begin
    elapsed_sum = {1'b0, elapsed_q} + (TIME_W+1)'(sample_period_q);
    elapsed_nx  = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
    seed        = elapsed_nx < prefill_time_q;
    pr          = seed ? raw_q : prev_raw_q;
    pl          = seed ? raw_q : prev_limited_q;
    r1          = (prev_limited_q > max_valid_q) ? '0 : raw_q;
    r2          = (r1 > reacquire_q && pr < dropout_q) ? pr : r1;
    diff        = (r2 >= pr) ? r2 - pr : pr - r2;
  end

  // slew limit
  logic [RANGE_W:0]   lim_up, lim_dn_sum;
  logic [RANGE_W-1:0] limited;

  always_comb begin
    lim_up     = {1'b0, prev_limited_q} + {1'b0, step_q};
    lim_dn_sum = {1'b0, raw_q} + {1'b0, step_q};
    if (jump_q) begin
      limited = prev_limited_q;
    end else if ({1'b0, raw_q} > lim_up) begin
      limited = lim_up[RANGE_W-1:0];
    end else if (lim_dn_sum < {1'b0, prev_limited_q}) begin
      limited = prev_limited_q - step_q;
    end else begin
      limited = raw_q;
    end
  end

  // operand selection
  logic signed [ACC_W-1:0] ext_a, ext_b, ext_rq;

  always_comb begin
    ext_a  = ACC_W'(state_a_q);
    ext_b  = ACC_W'(state_b_q);
    ext_rq = ACC_W'({prev_limited_q, {STATE_FRAC_BITS{1'b0}}});
    mul_cmd.start = !pend_q &&
                    (state_q == S_JUMP || state_q == S_STEP || state_q == S_FILT);
    mul_cmd.accum = (state_q == S_FILT) &&
                    !(term_q == T_AA || term_q == T_BA || term_q == T_YA);
    mcand  = ACC_W'(jump_limit_q);
    mplier = SER_W'(sample_period_q);
    if (state_q == S_STEP) begin
      mcand = ACC_W'(slew_limit_q);
    end else if (state_q == S_FILT) begin
      unique case (term_q)
        T_AA: begin mcand = ext_a;  mplier = C_AA; end
        T_AB: begin mcand = -ext_b; mplier = C_AB; end
        T_AR: begin mcand = ext_rq; mplier = C_AR; end
        T_BA: begin mcand = ext_a;  mplier = C_BA; end
        T_BB: begin mcand = ext_b;  mplier = C_BB; end
        T_BR: begin mcand = ext_rq; mplier = C_BR; end
        T_YA: begin mcand = ext_a;  mplier = C_YA; end
        T_YB: begin mcand = ext_b;  mplier = C_YB; end
        T_YR: begin mcand = ext_rq; mplier = C_YR; end
        default: begin mcand = '0; mplier = '0; end
      endcase
    end
  end

  // rounding and saturation
  logic signed [ACC_W-1:0]   rnd_c, rnd_y;
  logic signed [STATE_W-1:0] sat_c;
  logic [RANGE_W-1:0]        sat_y;

  always_comb begin
    rnd_c = (acc + HALF_C) >>> COEF_FRAC_BITS;
    rnd_y = (acc + HALF_Y) >>> Y_SH;
    if (rnd_c > S32_MAX) begin
      sat_c = ST_MAX;
    end else if (rnd_c < S32_MIN) begin
      sat_c = ST_MIN;
    end else begin
      sat_c = rnd_c[STATE_W-1:0];
    end
    if (rnd_y[ACC_W-1]) begin
      sat_y = '0;
    end else if (rnd_y > Y_MAX) begin
      sat_y = '1;
    end else begin
      sat_y = rnd_y[RANGE_W-1:0];
    end
  end

  assign sample_i.ready         = (state_q == S_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.out_range     = out_range_q;
  assign result_o.filter_active = out_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      term_q         <= T_AA;
      pend_q         <= 1'b0;
      raw_q          <= '0;
      diff_q         <= '0;
      step_q         <= '0;
      y_q            <= '0;
      jump_q         <= 1'b0;
      elapsed_q      <= '0;
      prev_raw_q     <= '0;
      prev_limited_q <= '0;
      state_a_q      <= '0;
      state_b_q      <= '0;
      na_q           <= '0;
      out_valid_q    <= 1'b0;
      out_active_q   <= 1'b0;
      out_range_q    <= '0;
    end else begin
      if (result_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (sample_i.valid) begin
            raw_q   <= sample_i.raw_range;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          elapsed_q      <= elapsed_nx;
          prev_raw_q     <= r2;
          prev_limited_q <= pl;
          raw_q          <= r2;
          diff_q         <= diff;
          state_q        <= S_JUMP;
        end
        S_JUMP: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (mul_done) begin
            pend_q  <= 1'b0;
            jump_q  <= {diff_q, 16'h0000} > acc[31:0];
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (mul_done) begin
            pend_q  <= 1'b0;
            step_q  <= acc[31:16];
            state_q <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          prev_limited_q <= limited;
          term_q         <= T_AA;
          state_q        <= S_FILT;
        end
        S_FILT: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (mul_done) begin
            pend_q <= 1'b0;
            if (term_q == T_AR) begin
              na_q <= sat_c;
            end
            if (term_q == T_BR) begin
              state_a_q <= na_q;
              state_b_q <= sat_c;
            end
            if (term_q == T_YR) begin
              y_q     <= sat_y;
              state_q <= S_OUT;
            end else begin
              term_q <= term_e'(4'(term_q + 4'd1));
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || result_o.ready) begin
            out_valid_q  <= 1'b1;
            out_active_q <= elapsed_q >= bypass_time_q;
            out_range_q  <= (elapsed_q >= bypass_time_q) ? y_q : prev_limited_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/lrsf_sermul.sv @@
// Digit-serial signed multiply-accumulate unit, DIGIT_W multiplier bits per cycle.
// Depends on lrsf_pkg.
module lrsf_sermul import lrsf_pkg::*; #(
  parameter int unsigned ACC_W = 66,
  parameter int unsigned SER_W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lrsf_mul_cmd_t           cmd_i,
  input  logic signed [ACC_W-1:0] mcand_i,
  input  logic [SER_W-1:0]        mplier_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int unsigned ND    = (SER_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned MP_W  = ND * DIGIT_W;
  localparam int unsigned CNT_W = $clog2(ND + 1);

  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] mcand_q;
  logic [MP_W-1:0]         mplier_q;
  logic signed [ACC_W-1:0] part;

  assign part   = mcand_q * $signed({1'b0, mplier_q[DIGIT_W-1:0]});
  assign done_o = done_q;
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (cmd_i.start) begin
        cnt_q <= CNT_W'(ND);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q  <= mcand_i;
      mplier_q <= MP_W'(mplier_i);
      if (!cmd_i.accum) begin
        acc_q <= '0;
      end
    end else if (cnt_q != '0) begin
      acc_q    <= acc_q + part;
      mcand_q  <= mcand_q <<< DIGIT_W;
      mplier_q <= mplier_q >> DIGIT_W;
    end
  end

endmodule
